// ===== src/pearson_correlation_engine_defines.svh =====
// Assertion macros used by the correlation engine controller.
`ifndef PEARSON_CORRELATION_ENGINE_DEFINES_SVH
`define PEARSON_CORRELATION_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that an antecedent implies a consequent in the same cycle.
`define PCE_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define PCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PCE_ASSERT_IMPLY(label, ante, cons, msg)
`define PCE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/pce_pkg.sv =====
// Types and constants shared by the correlation engine modules.
package pce_pkg;

	localparam int MAX_SAMPLES = 65536;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_LOAD,
		ST_RUN,
		ST_WRITE,
		ST_CHECK,
		ST_SRCH_INIT,
		ST_SRCH_A,
		ST_SRCH_B,
		ST_SRCH_C,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_N_SXY,
		OP_SX_SY,
		OP_N_SXX,
		OP_SX_SX,
		OP_N_SYY,
		OP_SY_SY,
		OP_DX_DY,
		OP_NUM_NUM
	} op_t;

	typedef struct packed {
		logic accum;
		logic load;
		logic run;
		logic write;
		logic srch_init;
		logic srch_a;
		logic srch_b;
		logic srch_c;
		logic emit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic degenerate;
		logic srch_last;
		logic out_free;
	} status_t;

endpackage

// ===== src/pce_ctrl.sv =====
// Controller state machine sequencing accumulation, products, root search and result.
`include "pearson_correlation_engine_defines.svh"

module pce_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_pair,
	output logic              in_ready,
	input  pce_pkg::status_t  status,
	output pce_pkg::cmd_t     cmd
);

	pce_pkg::state_t state_q, state_d;
	pce_pkg::op_t    op_q, op_d;

	// Hold state and current product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pce_pkg::ST_ACC;
			op_q    <= pce_pkg::OP_N_SXY;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// Advance state
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		case (state_q)
			pce_pkg::ST_ACC: begin
				if (in_valid && last_pair) begin
					state_d = pce_pkg::ST_LOAD;
					op_d    = pce_pkg::OP_N_SXY;
				end
			end
			pce_pkg::ST_LOAD:  state_d = pce_pkg::ST_RUN;
			pce_pkg::ST_RUN: begin
				if (status.mul_done) state_d = pce_pkg::ST_WRITE;
			end
			pce_pkg::ST_WRITE: begin
				if (op_q == pce_pkg::OP_SY_SY) begin
					state_d = pce_pkg::ST_CHECK;
				end else if (op_q == pce_pkg::OP_NUM_NUM) begin
					state_d = pce_pkg::ST_SRCH_INIT;
				end else begin
					state_d = pce_pkg::ST_LOAD;
					op_d    = pce_pkg::op_t'(op_q + 3'd1);
				end
			end
			pce_pkg::ST_CHECK: begin
				if (status.degenerate) begin
					state_d = pce_pkg::ST_EMIT;
				end else begin
					state_d = pce_pkg::ST_LOAD;
					op_d    = pce_pkg::OP_DX_DY;
				end
			end
			pce_pkg::ST_SRCH_INIT: state_d = pce_pkg::ST_SRCH_A;
			pce_pkg::ST_SRCH_A:    state_d = pce_pkg::ST_SRCH_B;
			pce_pkg::ST_SRCH_B:    state_d = pce_pkg::ST_SRCH_C;
			pce_pkg::ST_SRCH_C: begin
				state_d = status.srch_last ? pce_pkg::ST_EMIT : pce_pkg::ST_SRCH_A;
			end
			pce_pkg::ST_EMIT: begin
				if (status.out_free) state_d = pce_pkg::ST_ACC;
			end
			default: state_d = pce_pkg::ST_ACC;
		endcase
	end

	// Drive commands
	always_comb begin
		in_ready      = (state_q == pce_pkg::ST_ACC);
		cmd           = '0;
		cmd.op        = op_q;
		cmd.accum     = in_valid && (state_q == pce_pkg::ST_ACC);
		cmd.load      = (state_q == pce_pkg::ST_LOAD);
		cmd.run       = (state_q == pce_pkg::ST_RUN);
		cmd.write     = (state_q == pce_pkg::ST_WRITE);
		cmd.srch_init = (state_q == pce_pkg::ST_SRCH_INIT);
		cmd.srch_a    = (state_q == pce_pkg::ST_SRCH_A);
		cmd.srch_b    = (state_q == pce_pkg::ST_SRCH_B);
		cmd.srch_c    = (state_q == pce_pkg::ST_SRCH_C);
		cmd.emit      = (state_q == pce_pkg::ST_EMIT) && status.out_free;
	end

	`PCE_ASSERT_NEXT(a_last_starts, in_valid && in_ready && last_pair, state_q == pce_pkg::ST_LOAD, "last word did not start the result")
	`PCE_ASSERT_IMPLY(a_emit_free, cmd.emit, status.out_free, "result loaded over a waiting one")
	`PCE_ASSERT_IMPLY(a_search_op, state_q == pce_pkg::ST_SRCH_INIT, op_q == pce_pkg::OP_NUM_NUM, "search began before all products")
	`PCE_ASSERT_NEXT(a_emit_idle, cmd.emit, state_q == pce_pkg::ST_ACC && in_ready, "no return to accumulation after result")

endmodule

// ===== src/pce_datapath.sv =====
// Datapath: running sums, shared limb multiplier, root search and result register.
module pce_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [15:0]  x_sample,
	input  logic signed [15:0]  y_sample,
	input  pce_pkg::cmd_t       cmd,
	output pce_pkg::status_t    status,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  coefficient,
	output logic                degenerate,
	output logic                overflowed,
	output logic [16:0]         pair_count
);

	logic [16:0]         n_q;
	logic signed [32:0]  sx_q, sy_q;
	logic [46:0]         sxx_q, syy_q;
	logic signed [47:0]  sxy_q;
	logic                drop_q;
	logic signed [31:0]  xx, yy, xy;

	logic signed [65:0]  t0_q, num_q, dx_q, dy_q;
	logic [127:0]        d_q, r_q;
	logic [63:0]         ma_q, mb_q;
	logic                neg_q;
	logic [127:0]        acc_q;
	logic [2:0]          cnt_q;
	logic [63:0]         pp_s1;
	logic [1:0]          sh_s1;
	logic                pp_v_s1;
	logic signed [65:0]  opa, opb, absa, absb;
	logic signed [128:0] val;
	logic                degen;

	logic [15:0]         q_q;
	logic [3:0]          k_q;
	logic [159:0]        t_q, c_q, rhs;
	logic [143:0]        u_q;
	logic [15:0]         qneg;

	assign xx = x_sample * x_sample;
	assign yy = y_sample * y_sample;
	assign xy = x_sample * y_sample;

	// Accumulate pairs, drop beyond the maximum, clear after a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
			sxx_q  <= '0;
			syy_q  <= '0;
			sxy_q  <= '0;
			drop_q <= 1'b0;
		end else if (cmd.emit) begin
			n_q    <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
			sxx_q  <= '0;
			syy_q  <= '0;
			sxy_q  <= '0;
			drop_q <= 1'b0;
		end else if (cmd.accum) begin
			if (n_q < 17'(pce_pkg::MAX_SAMPLES)) begin
				n_q   <= n_q + 17'd1;
				sx_q  <= sx_q + 33'(x_sample);
				sy_q  <= sy_q + 33'(y_sample);
				sxx_q <= sxx_q + 47'($unsigned(xx));
				syy_q <= syy_q + 47'($unsigned(yy));
				sxy_q <= sxy_q + 48'(xy);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	// Select product operands
	always_comb begin
		case (cmd.op)
			pce_pkg::OP_N_SXY: begin
				opa = $signed({49'd0, n_q});
				opb = 66'(sxy_q);
			end
			pce_pkg::OP_SX_SY: begin
				opa = 66'(sx_q);
				opb = 66'(sy_q);
			end
			pce_pkg::OP_N_SXX: begin
				opa = $signed({49'd0, n_q});
				opb = $signed({19'd0, sxx_q});
			end
			pce_pkg::OP_SX_SX: begin
				opa = 66'(sx_q);
				opb = 66'(sx_q);
			end
			pce_pkg::OP_N_SYY: begin
				opa = $signed({49'd0, n_q});
				opb = $signed({19'd0, syy_q});
			end
			pce_pkg::OP_SY_SY: begin
				opa = 66'(sy_q);
				opb = 66'(sy_q);
			end
			pce_pkg::OP_DX_DY: begin
				opa = dx_q;
				opb = dy_q;
			end
			pce_pkg::OP_NUM_NUM: begin
				opa = num_q;
				opb = num_q;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		absa = opa[65] ? -opa : opa;
		absb = opb[65] ? -opb : opb;
		val  = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
	end

	// Multiply magnitudes limb by limb, register each partial product before adding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			pp_v_s1 <= 1'b0;
		end else if (cmd.load) begin
			cnt_q   <= '0;
			pp_v_s1 <= 1'b0;
		end else if (cmd.run) begin
			pp_v_s1 <= !cnt_q[2];
			if (!cnt_q[2]) cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ma_q  <= absa[63:0];
			mb_q  <= absb[63:0];
			neg_q <= opa[65] ^ opb[65];
			acc_q <= '0;
		end else if (cmd.run) begin
			pp_s1 <= (cnt_q[1] ? ma_q[63:32] : ma_q[31:0]) *
				(cnt_q[0] ? mb_q[63:32] : mb_q[31:0]);
			sh_s1 <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
			if (pp_v_s1) acc_q <= acc_q + ({64'd0, pp_s1} << {sh_s1, 5'd0});
		end
	end

	// Store signed products and differences
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			case (cmd.op)
				pce_pkg::OP_N_SXY, pce_pkg::OP_N_SXX, pce_pkg::OP_N_SYY: t0_q <= 66'(val);
				pce_pkg::OP_SX_SY:   num_q <= t0_q - 66'(val);
				pce_pkg::OP_SX_SX:   dx_q  <= t0_q - 66'(val);
				pce_pkg::OP_SY_SY:   dy_q  <= t0_q - 66'(val);
				pce_pkg::OP_DX_DY:   d_q   <= acc_q;
				pce_pkg::OP_NUM_NUM: r_q   <= acc_q;
				default: ;
			endcase
		end
	end

	assign degen = dx_q[65] || (dx_q == '0) || dy_q[65] || (dy_q == '0);
	assign rhs   = {2'b00, r_q, 30'd0};

	// Find the largest q with q*q*dx*dy <= 2^30*num^2, one bit per three steps
	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			q_q <= '0;
			k_q <= 4'd15;
			t_q <= '0;
			u_q <= '0;
		end else if (cmd.srch_a) begin
			c_q <= t_q + (160'(u_q) << (5'(k_q) + 5'd1));
		end else if (cmd.srch_b) begin
			c_q <= c_q + (160'(d_q) << {k_q, 1'b0});
		end else if (cmd.srch_c) begin
			if (c_q <= rhs) begin
				t_q      <= c_q;
				u_q      <= u_q + (144'(d_q) << k_q);
				q_q[k_q] <= 1'b1;
			end
			k_q <= k_q - 4'd1;
		end
	end

	assign qneg = 16'd0 - q_q;

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			degenerate <= degen;
			overflowed <= drop_q;
			pair_count <= n_q;
			if (degen) begin
				coefficient <= '0;
			end else if (num_q[65]) begin
				coefficient <= $signed(qneg);
			end else begin
				coefficient <= q_q[15] ? 16'sd32767 : $signed(q_q);
			end
		end
	end

	assign status.mul_done   = cnt_q[2];
	assign status.degenerate = degen;
	assign status.srch_last  = (k_q == 4'd0);
	assign status.out_free   = !out_valid || out_ready;

endmodule

// ===== src/pearson_correlation_engine.sv =====
// Top level of the Pearson correlation engine.
// Sample pairs are accepted one per clock cycle into exact running sums. The word flagged
// last_pair starts the result computation, during which no pair is accepted: eight wide
// products (six when either series has zero spread) run on one shared 32x32 multiplier,
// then, unless a series has zero spread, a bit-by-bit root search finds one coefficient
// bit at a time. The result waits in an output register, and accumulation of the next
// data set resumes while it waits.
module pearson_correlation_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] x_sample,
	input  logic signed [15:0] y_sample,
	input  logic               last_pair,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] coefficient,
	output logic               degenerate,
	output logic               overflowed,
	output logic [16:0]        pair_count
);

	pce_pkg::cmd_t    cmd;
	pce_pkg::status_t status;

	pce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_pair (last_pair),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	pce_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.x_sample    (x_sample),
		.y_sample    (y_sample),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.coefficient (coefficient),
		.degenerate  (degenerate),
		.overflowed  (overflowed),
		.pair_count  (pair_count)
	);

endmodule
